// ===== hw/rtl/srd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted record difference package
// Record, result and handshake types shared by the sorted record diff block.
// ---------------------------------------------------------------------------
package srd_pkg;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 288;
    localparam int CAP_W     = 16;

    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_CURRENT,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        KIND_GONE,
        KIND_NEW,
        KIND_MOVED,
        KIND_GONE_CNT,
        KIND_NEW_CNT,
        KIND_MOVED_CNT,
        KIND_SAME_CNT
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INVALID,
        ST_CAPACITY,
        ST_OVERFLOW,
        ST_FULL
    } t_status;

    typedef struct packed {
        logic [30:0] prov;
        logic [30:0] typ;
        logic [30:0] amt;
        logic [31:0] own;
    } t_rec;

    typedef struct packed {
        logic [30:0] key;
        t_rec        rec;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] key_or_count;
        t_rec        prior;
        t_rec        after;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    flush;
        t_result item;
    } t_oreq;

    typedef struct packed {
        logic push_ok;
        logic pend_v;
        logic out_free;
    } t_ostat;

endpackage

// ===== hw/rtl/srd_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Previous record store
// Single-port-write, single-port-read memory with a registered read.
// ---------------------------------------------------------------------------
module srd_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  srd_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output srd_pkg::t_entry      o_rdata
);

    srd_pkg::t_entry r_mem [DEPTH];
    srd_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/srd_out.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result output stage
// Holds one pending result until its last flag is known, then an output
// register that drives the master stream.
// ---------------------------------------------------------------------------
module srd_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srd_pkg::t_oreq                    i_oreq,
    output srd_pkg::t_ostat                   o_ostat,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, key_or_count, before_province, before_type, before_amount,
    // before_owner, after_province, after_type, after_amount, after_owner
    output logic [srd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // kind
    output logic [2:0]                        o_m_tuser,
    output logic                              o_m_tlast
);

    srd_pkg::t_result r_out, n_out;
    srd_pkg::t_result r_pend, n_pend;
    logic             r_out_v, n_out_v;
    logic             r_out_last, n_out_last;
    logic             r_pend_v, n_pend_v;
    logic             out_free;

    assign out_free = !r_out_v || i_m_tready;

    always_comb begin
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_m_tready;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        if (i_oreq.push) begin
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out_last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_pend   = i_oreq.item;
            n_pend_v = 1'b1;
        end else if (i_oreq.flush && r_pend_v && out_free) begin
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_out_v    = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_pend     <= n_pend;
    end

    assign o_ostat.push_ok  = !r_pend_v || out_free;
    assign o_ostat.pend_v   = r_pend_v;
    assign o_ostat.out_free = out_free;

    assign o_m_tvalid = r_out_v;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {3'b000,
                         r_out.after.own, r_out.after.amt, r_out.after.typ, r_out.after.prov,
                         r_out.prior.own, r_out.prior.amt, r_out.prior.typ,
                         r_out.prior.prov, r_out.key_or_count, r_out.status};

endmodule

// ===== hw/rtl/srd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Merge-join controller
// Decodes input transfers, loads the store, walks it against current
// records, keeps the counters and sticky error, and issues results.
// ---------------------------------------------------------------------------
module srd_ctrl #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int FW    = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [srd_pkg::CAP_W-1:0]         i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [srd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output srd_pkg::t_entry                   o_wdata,
    output logic [AW-1:0]                     o_raddr,
    input  srd_pkg::t_entry                   i_rdata,
    output srd_pkg::t_oreq                    o_oreq,
    input  srd_pkg::t_ostat                   i_ostat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FETCH,
        S_COUNT,
        S_TAIL
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_flush_mode, n_flush_mode;
    logic [30:0]               r_key, n_key;
    srd_pkg::t_rec             r_cur, n_cur;
    logic [FW-1:0]             r_fill, n_fill;
    logic [FW-1:0]             r_read_pos, n_read_pos;
    logic                      r_load_seen, n_load_seen;
    logic [30:0]               r_last_load, n_last_load;
    logic                      r_cur_seen, n_cur_seen;
    logic [30:0]               r_last_cur, n_last_cur;
    logic [srd_pkg::CAP_W-1:0] r_changes, n_changes;
    logic [srd_pkg::CAP_W-1:0] r_capacity;
    logic [31:0]               r_gone, n_gone;
    logic [31:0]               r_new, n_new;
    logic [31:0]               r_moved, n_moved;
    logic [31:0]               r_same, n_same;
    srd_pkg::t_status          r_err, n_err;
    logic [1:0]                r_cidx, n_cidx;

    function automatic srd_pkg::t_status change_check(
        input logic [srd_pkg::CAP_W-1:0] changes,
        input logic [srd_pkg::CAP_W-1:0] cap,
        input logic [31:0]               counter
    );
        srd_pkg::t_status res;
        res = srd_pkg::ST_OK;
        if (changes >= cap) begin
            res = srd_pkg::ST_CAPACITY;
        end else if (counter == 32'hFFFF_FFFF) begin
            res = srd_pkg::ST_OVERFLOW;
        end
        return res;
    endfunction

    always_comb begin
        logic [30:0]        in_key;
        srd_pkg::t_rec      in_rec;
        logic               in_bad;
        logic               accept;
        logic               head_v;
        logic               drain;
        logic               differ;
        srd_pkg::t_status   chk;
        srd_pkg::t_result   err_item;

        in_key     = i_s_tdata[30:0];
        in_rec.prov = i_s_tdata[62:32];
        in_rec.typ  = i_s_tdata[94:64];
        in_rec.amt  = i_s_tdata[126:96];
        in_rec.own  = i_s_tdata[159:128];
        in_bad     = i_s_tdata[31] | i_s_tdata[63] | i_s_tdata[95] | i_s_tdata[127];
        accept     = i_s_tvalid && (r_state == S_IDLE);
        head_v     = r_read_pos < r_fill;
        drain      = head_v && (r_flush_mode || (i_rdata.key < r_key));
        differ     = (i_rdata.rec.prov != r_cur.prov) || (i_rdata.rec.typ != r_cur.typ) ||
                     (i_rdata.rec.own != r_cur.own);
        chk        = srd_pkg::ST_OK;
        err_item   = '0;

        n_state      = r_state;
        n_flush_mode = r_flush_mode;
        n_key        = r_key;
        n_cur        = r_cur;
        n_fill       = r_fill;
        n_read_pos   = r_read_pos;
        n_load_seen  = r_load_seen;
        n_last_load  = r_last_load;
        n_cur_seen   = r_cur_seen;
        n_last_cur   = r_last_cur;
        n_changes    = r_changes;
        n_gone       = r_gone;
        n_new        = r_new;
        n_moved      = r_moved;
        n_same       = r_same;
        n_err        = r_err;
        n_cidx       = r_cidx;

        o_oreq       = '0;
        o_we         = 1'b0;
        o_wdata.key  = in_key;
        o_wdata.rec  = in_rec;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (srd_pkg::t_op'(i_s_tuser))
                        srd_pkg::OP_START: begin
                            n_fill      = '0;
                            n_read_pos  = '0;
                            n_load_seen = 1'b0;
                            n_cur_seen  = 1'b0;
                            n_changes   = '0;
                            n_gone      = '0;
                            n_new       = '0;
                            n_moved     = '0;
                            n_same      = '0;
                            n_err       = srd_pkg::ST_OK;
                        end
                        srd_pkg::OP_LOAD: begin
                            if (r_err == srd_pkg::ST_OK) begin
                                if (in_bad || r_cur_seen ||
                                    (r_load_seen && (in_key <= r_last_load))) begin
                                    n_err = srd_pkg::ST_INVALID;
                                end else if (r_fill == FW'(DEPTH)) begin
                                    n_err = srd_pkg::ST_FULL;
                                end else begin
                                    o_we        = 1'b1;
                                    n_fill      = r_fill + 1'b1;
                                    n_load_seen = 1'b1;
                                    n_last_load = in_key;
                                end
                            end
                        end
                        srd_pkg::OP_CURRENT: begin
                            if (r_err == srd_pkg::ST_OK) begin
                                if (in_bad || (r_cur_seen && (in_key <= r_last_cur))) begin
                                    n_err = srd_pkg::ST_INVALID;
                                end else begin
                                    n_cur_seen   = 1'b1;
                                    n_last_cur   = in_key;
                                    n_key        = in_key;
                                    n_cur        = in_rec;
                                    n_flush_mode = 1'b0;
                                    n_state      = S_CMP;
                                end
                            end
                        end
                        srd_pkg::OP_FINISH: begin
                            n_cidx = '0;
                            if (r_err == srd_pkg::ST_OK) begin
                                n_flush_mode = 1'b1;
                                n_state      = S_CMP;
                            end else begin
                                n_state = S_COUNT;
                            end
                        end
                        default: ;
                    endcase
                    if ((r_err == srd_pkg::ST_OK) && (n_err != srd_pkg::ST_OK)) begin
                        err_item.kind   = srd_pkg::KIND_GONE;
                        err_item.status = n_err;
                        o_oreq.push     = 1'b1;
                        o_oreq.item     = err_item;
                        n_state         = S_TAIL;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_ostat.push_ok) begin
                    if (drain) begin
                        chk = change_check(r_changes, r_capacity, r_gone);
                        if (chk == srd_pkg::ST_OK) begin
                            o_oreq.push              = 1'b1;
                            o_oreq.item.kind         = srd_pkg::KIND_GONE;
                            o_oreq.item.status       = srd_pkg::ST_OK;
                            o_oreq.item.key_or_count = {1'b0, i_rdata.key};
                            o_oreq.item.prior        = i_rdata.rec;
                            n_changes                = r_changes + 1'b1;
                            n_gone                   = r_gone + 32'd1;
                            n_read_pos               = r_read_pos + 1'b1;
                            n_state                  = S_FETCH;
                        end
                    end else if (r_flush_mode) begin
                        n_state = S_COUNT;
                    end else if (head_v && (i_rdata.key == r_key)) begin
                        n_read_pos = r_read_pos + 1'b1;
                        if (differ) begin
                            chk = change_check(r_changes, r_capacity, r_moved);
                            if (chk == srd_pkg::ST_OK) begin
                                o_oreq.push              = 1'b1;
                                o_oreq.item.kind         = srd_pkg::KIND_MOVED;
                                o_oreq.item.status       = srd_pkg::ST_OK;
                                o_oreq.item.key_or_count = {1'b0, r_key};
                                o_oreq.item.prior        = i_rdata.rec;
                                o_oreq.item.after        = r_cur;
                                n_changes                = r_changes + 1'b1;
                                n_moved                  = r_moved + 32'd1;
                            end
                        end else if (r_same == 32'hFFFF_FFFF) begin
                            chk = srd_pkg::ST_OVERFLOW;
                        end else begin
                            n_same = r_same + 32'd1;
                        end
                        n_state = (i_ostat.pend_v || o_oreq.push || (chk != srd_pkg::ST_OK)) ?
                                  S_TAIL : S_IDLE;
                    end else begin
                        chk = change_check(r_changes, r_capacity, r_new);
                        if (chk == srd_pkg::ST_OK) begin
                            o_oreq.push              = 1'b1;
                            o_oreq.item.kind         = srd_pkg::KIND_NEW;
                            o_oreq.item.status       = srd_pkg::ST_OK;
                            o_oreq.item.key_or_count = {1'b0, r_key};
                            o_oreq.item.after        = r_cur;
                            n_changes                = r_changes + 1'b1;
                            n_new                    = r_new + 32'd1;
                        end
                        n_state = S_TAIL;
                    end
                    if (chk != srd_pkg::ST_OK) begin
                        n_err = chk;
                        if (r_flush_mode) begin
                            n_state = S_COUNT;
                        end else begin
                            err_item.kind   = srd_pkg::KIND_GONE;
                            err_item.status = chk;
                            o_oreq.push     = 1'b1;
                            o_oreq.item     = err_item;
                            n_state         = S_TAIL;
                        end
                    end
                end
            end
            S_COUNT: begin
                if (i_ostat.push_ok) begin
                    o_oreq.push        = 1'b1;
                    o_oreq.item.status = r_err;
                    case (r_cidx)
                        2'd0: begin
                            o_oreq.item.kind         = srd_pkg::KIND_GONE_CNT;
                            o_oreq.item.key_or_count = r_gone;
                        end
                        2'd1: begin
                            o_oreq.item.kind         = srd_pkg::KIND_NEW_CNT;
                            o_oreq.item.key_or_count = r_new;
                        end
                        2'd2: begin
                            o_oreq.item.kind         = srd_pkg::KIND_MOVED_CNT;
                            o_oreq.item.key_or_count = r_moved;
                        end
                        default: begin
                            o_oreq.item.kind         = srd_pkg::KIND_SAME_CNT;
                            o_oreq.item.key_or_count = r_same;
                        end
                    endcase
                    n_cidx = r_cidx + 2'd1;
                    if (r_cidx == 2'd3) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (!i_ostat.pend_v) begin
                    n_state = S_IDLE;
                end else begin
                    o_oreq.flush = 1'b1;
                    if (i_ostat.out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flush_mode <= 1'b0;
            r_fill       <= '0;
            r_read_pos   <= '0;
            r_load_seen  <= 1'b0;
            r_last_load  <= '0;
            r_cur_seen   <= 1'b0;
            r_last_cur   <= '0;
            r_changes    <= '0;
            r_capacity   <= '1;
            r_gone       <= '0;
            r_new        <= '0;
            r_moved      <= '0;
            r_same       <= '0;
            r_err        <= srd_pkg::ST_OK;
            r_cidx       <= '0;
        end else begin
            r_state      <= n_state;
            r_flush_mode <= n_flush_mode;
            r_fill       <= n_fill;
            r_read_pos   <= n_read_pos;
            r_load_seen  <= n_load_seen;
            r_last_load  <= n_last_load;
            r_cur_seen   <= n_cur_seen;
            r_last_cur   <= n_last_cur;
            r_changes    <= n_changes;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            r_gone       <= n_gone;
            r_new        <= n_new;
            r_moved      <= n_moved;
            r_same       <= n_same;
            r_err        <= n_err;
            r_cidx       <= n_cidx;
        end
        r_key <= n_key;
        r_cur <= n_cur;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_waddr    = r_fill[AW-1:0];
    assign o_raddr    = r_read_pos[AW-1:0];

endmodule

// ===== hw/rtl/sorted_record_diff.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted record difference
// A load writes the store, or is rejected with an error result. A current
// record first drains each disappeared stored record before it, with a fetch
// step after each one for the registered store read, then gives its new or
// moved result, if any, and releases its last result. A finish flushes the
// remaining stored records, then issues four count results. Output stalls can
// hold these steps. Reset is synchronous, active low, and leaves the store
// uncleared, as reads stay below the fill count.
module sorted_record_diff #(
    parameter int PREV_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [srd_pkg::CAP_W-1:0]         i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pop_id, province, kind_type, amount, owner_key
    input  logic [srd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // op
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, key_or_count, before_province, before_type, before_amount,
    // before_owner, after_province, after_type, after_amount, after_owner
    output logic [srd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // kind
    output logic [2:0]                        o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int AW = (PREV_DEPTH > 1) ? $clog2(PREV_DEPTH) : 1;
    localparam int FW = $clog2(PREV_DEPTH + 1);

    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [AW-1:0]     st_raddr;
    srd_pkg::t_entry   st_wdata;
    srd_pkg::t_entry   st_rdata;
    srd_pkg::t_oreq    oreq;
    srd_pkg::t_ostat   ostat;

    srd_store #(
        .DEPTH (PREV_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    srd_ctrl #(
        .DEPTH (PREV_DEPTH),
        .AW    (AW),
        .FW    (FW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_we          (st_we),
        .o_waddr       (st_waddr),
        .o_wdata       (st_wdata),
        .o_raddr       (st_raddr),
        .i_rdata       (st_rdata),
        .o_oreq        (oreq),
        .i_ostat       (ostat)
    );

    srd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_oreq     (oreq),
        .o_ostat    (ostat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_store_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (i_s_tvalid && o_s_tready && (i_s_tuser == srd_pkg::OP_LOAD)))
        else $error("store written outside an accepted load transfer");

    a_error_item_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == srd_pkg::KIND_GONE) &&
         (o_m_tdata[2:0] != srd_pkg::ST_OK)) |-> o_m_tlast)
        else $error("error result is not the last of its transfer");

    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == srd_pkg::KIND_GONE_CNT) ||
                        (o_m_tuser == srd_pkg::KIND_NEW_CNT) ||
                        (o_m_tuser == srd_pkg::KIND_MOVED_CNT))) |-> !o_m_tlast)
        else $error("early count result marked last");

    a_same_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == srd_pkg::KIND_SAME_CNT)) |-> o_m_tlast)
        else $error("final count result not marked last");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted record difference testbench
// Drives snapshot loads, current records and finishes into the block, and
// predicts every change, error and count transfer with its own merge-join model.
// Each result transfer is compared field by field with the oldest expected
// one. Directed tests, random sessions under several idling patterns, and a
// long output hold-off follow one another.
// ---------------------------------------------------------------------------
module testbench;

    localparam int PREV_DEPTH     = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 90;

    typedef struct {
        srd_pkg::t_op op;
        logic [31:0]  key;
        logic [31:0]  prov;
        logic [31:0]  typ;
        logic [31:0]  amt;
        logic [31:0]  own;
    } t_stim;

    typedef struct {
        srd_pkg::t_kind   kind;
        srd_pkg::t_status status;
        logic             last;
        logic [31:0]      key_or_count;
        srd_pkg::t_rec    prior;
        srd_pkg::t_rec    after;
    } t_change;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [srd_pkg::CAP_W-1:0]     i_cfg_wr_data = '0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [srd_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic [1:0]                    i_s_tuser = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [srd_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [2:0]                    o_m_tuser;
    logic                          o_m_tlast;

    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;

    t_change pending_changes[$];

    // Merge-join state of the predictor.
    logic [31:0]      prev_key_mem [PREV_DEPTH];
    srd_pkg::t_rec    prev_rec_mem [PREV_DEPTH];
    int               prev_fill;
    int               prev_pos;
    longint           last_load_key;
    longint           last_cur_key;
    logic [31:0]      changes_made;
    logic [31:0]      change_tally [3];
    logic [31:0]      same_tally;
    srd_pkg::t_status diff_error;
    logic [15:0]      cap_limit;

    sorted_record_diff #(
        .PREV_DEPTH(PREV_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clear_diff_state();
        prev_fill = 0;
        prev_pos = 0;
        last_load_key = -1;
        last_cur_key = -1;
        changes_made = '0;
        change_tally[srd_pkg::KIND_GONE] = '0;
        change_tally[srd_pkg::KIND_NEW] = '0;
        change_tally[srd_pkg::KIND_MOVED] = '0;
        same_tally = '0;
        diff_error = srd_pkg::ST_OK;
    endfunction

    function automatic srd_pkg::t_rec to_rec(t_stim s);
        srd_pkg::t_rec r;
        r.prov = s.prov[30:0];
        r.typ  = s.typ[30:0];
        r.amt  = s.amt[30:0];
        r.own  = s.own;
        return r;
    endfunction

    function automatic void push_change(srd_pkg::t_kind k, srd_pkg::t_status st,
                                        logic [31:0] koc, srd_pkg::t_rec b,
                                        srd_pkg::t_rec a);
        t_change c;
        c.kind = k;
        c.status = st;
        c.last = 1'b0;
        c.key_or_count = koc;
        c.prior = b;
        c.after = a;
        pending_changes.push_back(c);
    endfunction

    function automatic srd_pkg::t_status take_change(srd_pkg::t_kind k);
        if (changes_made >= {16'h0, cap_limit}) return srd_pkg::ST_CAPACITY;
        if (change_tally[k] == 32'hFFFF_FFFF) return srd_pkg::ST_OVERFLOW;
        changes_made++;
        change_tally[k]++;
        return srd_pkg::ST_OK;
    endfunction

    function automatic void drain_gone(bit flush, logic [31:0] limit);
        srd_pkg::t_status e;
        while (diff_error == srd_pkg::ST_OK && prev_pos < prev_fill) begin
            if (!flush && prev_key_mem[prev_pos] >= limit) break;
            e = take_change(srd_pkg::KIND_GONE);
            if (e != srd_pkg::ST_OK) begin
                diff_error = e;
                break;
            end
            push_change(srd_pkg::KIND_GONE, srd_pkg::ST_OK, prev_key_mem[prev_pos],
                        prev_rec_mem[prev_pos], '0);
            prev_pos++;
        end
    endfunction

    function automatic void predict_merge(t_stim s);
        int               first;
        bit               bad;
        longint           kval;
        srd_pkg::t_rec    r;
        srd_pkg::t_rec    b;
        srd_pkg::t_status e;
        t_change          c;
        first = pending_changes.size();
        bad = s.key[31] | s.prov[31] | s.typ[31] | s.amt[31];
        kval = longint'({32'h0, s.key});
        r = to_rec(s);
        case (s.op)
            srd_pkg::OP_START: begin
                clear_diff_state();
            end
            srd_pkg::OP_FINISH: begin
                drain_gone(1'b1, '0);
                push_change(srd_pkg::KIND_GONE_CNT, diff_error,
                            change_tally[srd_pkg::KIND_GONE], '0, '0);
                push_change(srd_pkg::KIND_NEW_CNT, diff_error,
                            change_tally[srd_pkg::KIND_NEW], '0, '0);
                push_change(srd_pkg::KIND_MOVED_CNT, diff_error,
                            change_tally[srd_pkg::KIND_MOVED], '0, '0);
                push_change(srd_pkg::KIND_SAME_CNT, diff_error, same_tally, '0, '0);
            end
            default: begin
                if (diff_error == srd_pkg::ST_OK) begin
                    if (s.op == srd_pkg::OP_LOAD) begin
                        if (bad || kval <= last_load_key || last_cur_key >= 0) begin
                            diff_error = srd_pkg::ST_INVALID;
                        end else if (prev_fill >= PREV_DEPTH) begin
                            diff_error = srd_pkg::ST_FULL;
                        end else begin
                            prev_key_mem[prev_fill] = s.key;
                            prev_rec_mem[prev_fill] = r;
                            prev_fill++;
                            last_load_key = kval;
                        end
                    end else if (bad || kval <= last_cur_key) begin
                        diff_error = srd_pkg::ST_INVALID;
                    end else begin
                        last_cur_key = kval;
                        drain_gone(1'b0, s.key);
                        if (diff_error == srd_pkg::ST_OK) begin
                            if (prev_pos < prev_fill && prev_key_mem[prev_pos] == s.key) begin
                                b = prev_rec_mem[prev_pos];
                                prev_pos++;
                                if (b.prov != r.prov || b.typ != r.typ || b.own != r.own) begin
                                    e = take_change(srd_pkg::KIND_MOVED);
                                    if (e != srd_pkg::ST_OK) diff_error = e;
                                    else push_change(srd_pkg::KIND_MOVED, srd_pkg::ST_OK,
                                                     s.key, b, r);
                                end else if (same_tally == 32'hFFFF_FFFF) begin
                                    diff_error = srd_pkg::ST_OVERFLOW;
                                end else begin
                                    same_tally++;
                                end
                            end else begin
                                e = take_change(srd_pkg::KIND_NEW);
                                if (e != srd_pkg::ST_OK) diff_error = e;
                                else push_change(srd_pkg::KIND_NEW, srd_pkg::ST_OK,
                                                 s.key, '0, r);
                            end
                        end
                    end
                    if (diff_error != srd_pkg::ST_OK)
                        push_change(srd_pkg::KIND_GONE, diff_error, '0, '0, '0);
                end
            end
        endcase
        if (pending_changes.size() > first) begin
            c = pending_changes.pop_back();
            c.last = 1'b1;
            pending_changes.push_back(c);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_change want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_changes.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer of kind %0d", o_m_tuser));
            end else begin
                want = pending_changes.pop_front();
                check_field("kind", 32'(o_m_tuser), 32'(want.kind));
                check_field("status", 32'(o_m_tdata[2:0]), 32'(want.status));
                check_field("tlast", 32'(o_m_tlast), 32'(want.last));
                check_field("key_or_count", o_m_tdata[34:3], want.key_or_count);
                check_field("before_province", 32'(o_m_tdata[65:35]), 32'(want.prior.prov));
                check_field("before_type", 32'(o_m_tdata[96:66]), 32'(want.prior.typ));
                check_field("before_amount", 32'(o_m_tdata[127:97]), 32'(want.prior.amt));
                check_field("before_owner", o_m_tdata[159:128], want.prior.own);
                check_field("after_province", 32'(o_m_tdata[190:160]), 32'(want.after.prov));
                check_field("after_type", 32'(o_m_tdata[221:191]), 32'(want.after.typ));
                check_field("after_amount", 32'(o_m_tdata[252:222]), 32'(want.after.amt));
                check_field("after_owner", o_m_tdata[284:253], want.after.own);
            end
        end
    end

    // Result receiver, with random stalls and the long hold-off.
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_record(t_stim s);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= s.op;
        i_s_tdata <= {s.own, s.amt, s.typ, s.prov, s.key};
        do @(posedge i_clk); while (!o_s_tready);
        predict_merge(s);
    endtask

    task automatic send_fields(srd_pkg::t_op op, logic [31:0] key, logic [31:0] prov,
                               logic [31:0] typ, logic [31:0] amt, logic [31:0] own);
        t_stim s;
        s.op = op;
        s.key = key;
        s.prov = prov;
        s.typ = typ;
        s.amt = amt;
        s.own = own;
        send_record(s);
    endtask

    task automatic send_op(srd_pkg::t_op op);
        send_fields(op, '0, '0, '0, '0, '0);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_changes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_limit = value;
    endtask

    function automatic logic [31:0] rand_attr();
        return ($urandom_range(1) == 0) ? 32'($urandom_range(0, 2)) : ($urandom & 32'h7FFF_FFFF);
    endfunction

    function automatic t_stim rand_record(srd_pkg::t_op op, logic [31:0] key);
        t_stim s;
        s.op = op;
        s.key = key;
        s.prov = rand_attr();
        s.typ = rand_attr();
        s.amt = rand_attr();
        s.own = ($urandom_range(1) == 0) ? 32'($urandom_range(0, 2)) : $urandom;
        return s;
    endfunction

    task automatic test_basic_merge();
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_LOAD, 32'd0, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_LOAD, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF);
        send_fields(srd_pkg::OP_LOAD, 32'd9, 32'd1, 32'd2, 32'd3, 32'd4);
        send_fields(srd_pkg::OP_LOAD, 32'd12, 32'd1, 32'd2, 32'd3, 32'd4);
        send_fields(srd_pkg::OP_LOAD, 32'h7FFF_FFFF, 32'd5, 32'd6, 32'd7, 32'd8);
        send_fields(srd_pkg::OP_CURRENT, 32'd3, 32'd9, 32'd9, 32'd9, 32'd9);
        send_fields(srd_pkg::OP_CURRENT, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF);
        send_fields(srd_pkg::OP_CURRENT, 32'd9, 32'd1, 32'd7, 32'd3, 32'd4);
        send_fields(srd_pkg::OP_CURRENT, 32'd12, 32'd1, 32'd2, 32'd99, 32'd4);
        send_fields(srd_pkg::OP_CURRENT, 32'h7FFF_FFFF, 32'd6, 32'd6, 32'd7, 32'd9);
        send_op(srd_pkg::OP_FINISH);
        send_op(srd_pkg::OP_FINISH);
    endtask

    task automatic test_bad_records();
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_CURRENT, 32'd1, 32'h8000_0000, '0, '0, '0);
        send_fields(srd_pkg::OP_CURRENT, 32'd2, '0, '0, '0, '0);
        send_op(srd_pkg::OP_FINISH);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_LOAD, 32'd3, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_LOAD, 32'd3, '0, '0, '0, '0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_CURRENT, 32'd7, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_LOAD, 32'd9, '0, '0, '0, '0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_CURRENT, 32'd5, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_CURRENT, 32'd4, '0, '0, '0, '0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_LOAD, 32'h8000_0000, '0, '0, '0, '0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_LOAD, 32'd1, '0, 32'hFFFF_FFFF, '0, '0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_CURRENT, 32'd1, '0, '0, 32'h8000_0001, '0);
    endtask

    task automatic test_capacity_limit();
        wait_drained();
        write_capacity(16'd0);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_CURRENT, 32'd1, '0, '0, '0, '0);
        wait_drained();
        write_capacity(16'd2);
        send_op(srd_pkg::OP_START);
        send_fields(srd_pkg::OP_LOAD, 32'd1, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_LOAD, 32'd2, '0, '0, '0, '0);
        send_fields(srd_pkg::OP_LOAD, 32'd3, '0, '0, '0, '0);
        send_op(srd_pkg::OP_FINISH);
        wait_drained();
        write_capacity(16'hFFFF);
    endtask

    task automatic random_session(inout int sent);
        t_stim       prev_q[$];
        t_stim       cur_q[$];
        t_stim       plan[$];
        t_stim       s;
        logic [31:0] key;
        int          span;
        int          role;
        bit          full_store;
        bit          noisy;
        if (cap_limit != 16'hFFFF || $urandom_range(5) == 0) begin
            wait_drained();
            if (cap_limit != 16'hFFFF) begin
                write_capacity(16'hFFFF);
            end else begin
                case ($urandom_range(2))
                    0: write_capacity(16'd0);
                    1: write_capacity(16'($urandom_range(1, 6)));
                    default: write_capacity(16'($urandom_range(7, 65534)));
                endcase
            end
        end
        full_store = ($urandom_range(15) == 0);
        noisy = ($urandom_range(3) == 0);
        span = full_store ? $urandom_range(32, 33) : $urandom_range(1, 10);
        key = ($urandom_range(7) == 0) ? 32'h7FFF_FF00 : 32'($urandom_range(0, 1000));
        for (int i = 0; i < span; i++) begin
            key = key + 32'($urandom_range(1, 3));
            role = $urandom_range(3);
            if (full_store && role == 1) role = 0;
            if (role == 1) begin
                cur_q.push_back(rand_record(srd_pkg::OP_CURRENT, key));
            end else begin
                s = rand_record(srd_pkg::OP_LOAD, key);
                prev_q.push_back(s);
                if (role >= 2) begin
                    s.op = srd_pkg::OP_CURRENT;
                    case ($urandom_range(4))
                        1: s.prov = s.prov ^ 32'h1;
                        2: s.typ = s.typ ^ 32'h1;
                        3: s.amt = s.amt ^ 32'h1;
                        4: s.own = s.own ^ 32'h8000_0000;
                        default: ;
                    endcase
                    cur_q.push_back(s);
                end
            end
        end
        s = rand_record(srd_pkg::OP_START, '0);
        plan.push_back(s);
        foreach (prev_q[i]) plan.push_back(prev_q[i]);
        foreach (cur_q[i]) plan.push_back(cur_q[i]);
        s.op = srd_pkg::OP_FINISH;
        plan.push_back(s);
        if ($urandom_range(7) == 0) begin
            plan.push_back(rand_record(srd_pkg::OP_CURRENT, key + 32'd1));
            plan.push_back(s);
        end
        foreach (plan[i]) begin
            if (noisy && $urandom_range(19) == 0) begin
                s.op = srd_pkg::t_op'($urandom_range(3));
                s.key = $urandom;
                s.prov = $urandom;
                s.typ = $urandom;
                s.amt = $urandom;
                s.own = $urandom;
                send_record(s);
                sent++;
            end
            send_record(plan[i]);
            sent++;
        end
    endtask

    task automatic test_random_traffic(int src_pct, int snk_pct);
        int sent;
        sent = 0;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        while (sent < PHASE_ITEMS) random_session(sent);
    endtask

    task automatic test_output_hold_off();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_op(srd_pkg::OP_START);
        hold_go <= 1'b1;
        for (int i = 0; i < 30; i++)
            send_record(rand_record(srd_pkg::OP_CURRENT, 32'(10 * i + 1)));
        send_op(srd_pkg::OP_FINISH);
    endtask

    initial begin
        clear_diff_state();
        cap_limit = 16'hFFFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_merge();
        test_bad_records();
        test_capacity_limit();
        test_random_traffic(0, 0);
        test_random_traffic(46, 0);
        test_random_traffic(0, 46);
        test_random_traffic(24, 24);
        test_output_hold_off();
        wait_drained();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
